@@ rtl/core/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  localparam logic StatusOk         = 1'b0;
  localparam logic StatusIncomplete = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic       status_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]           count;
    result_t [MaxResults-1:0]    item;
  } group_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      t = ch - 8'h41;
      r.hit = 1'b1;
      r.value = t[5:0];
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      t = ch - 8'h61 + 8'd26;
      r.hit = 1'b1;
      r.value = t[5:0];
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      t = ch - 8'h30 + 8'd52;
      r.hit = 1'b1;
      r.value = t[5:0];
    end else if (ch == PlusChar) begin
      r.hit = 1'b1;
      r.value = 6'd62;
    end else if (ch == SlashChar) begin
      r.hit = 1'b1;
      r.value = 6'd63;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/base64_stream_decoder.sv @@
// Streaming base64 decoder, one text character per input beat.
// Input channel: in_char with end_of_text, handshake in_valid / in_stall.
// Output channel: one result per beat, out_byte or an end status
// (is_status, status_code), last_of_run on the final result of a character;
// handshake out_valid / out_stall.
// A character is latched in an input register, decoded while it sits
// there and its results (up to three bytes plus a status) are loaded as
// a group into a four-entry result buffer that drains one per cycle while
// out_stall is low. The first result of a character is offered once its
// group is loaded into the result buffer, behind the input register.
// Throughput: one character per cycle while in_stall is low. A character
// that yields results waits while an earlier group has more than one
// result left to deliver, or one left and out_stall high. A full group
// of four characters yields only three bytes, so a running text keeps one
// character per cycle while the receiver does not stall.
// Reset clears the group state and the input register's valid flag, and empties the result buffer.
// A stalled receiver holds the current result; once the buffer cannot take
// the next group, in_stall rises and the input register holds.
`default_nettype none

module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            is_status,
  output logic            status_code,
  output logic            last_of_run
);
  import b64d_pkg::*;

  logic       in_q_valid;
  logic [7:0] char_q;
  logic       eot_q;
  group_t     group;
  logic       free;
  logic       advance;
  logic       step;
  logic       load;

  assign advance  = (group.count == '0) || free;
  assign in_stall = in_q_valid && !advance;
  assign step     = in_q_valid && advance;
  assign load     = step && (group.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= in_char;
      eot_q  <= end_of_text;
    end
  end

  b64d_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .char_q (char_q),
    .eot_q  (eot_q),
    .group  (group)
  );

  b64d_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .group       (group),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_status   (is_status),
    .status_code (status_code),
    .last_of_run (last_of_run)
  );

  a_stall_needs_busy_buf: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result buffer");

  a_load_into_free_buf: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("group loaded over undelivered results");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_status) |-> last_of_run)
    else $error("status result not marked last of run");

  a_code_only_on_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_code) |-> is_status)
    else $error("status code set on a data result");

endmodule

`default_nettype wire

@@ rtl/core/b64d_decode.sv @@
`default_nettype none

module b64d_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      char_q,
  input  wire logic            eot_q,
  output b64d_pkg::group_t     group
);
  import b64d_pkg::*;

  logic [1:0]  sextet_count;
  logic [17:0] partial_bits;
  logic        pad_seen;
  logic [1:0]  sextet_count_next;
  logic [17:0] partial_bits_next;
  logic        pad_seen_next;

  sextet_t     lk;
  logic [23:0] word;
  logic [7:0]  data [3];
  logic [1:0]  n_data;
  logic [CountW-1:0] n_total;
  logic        code;

  assign lk   = sextet_of(char_q);
  assign word = {partial_bits, (char_q == PadChar) ? 6'd0 : lk.value};

  always_comb begin
    sextet_count_next = sextet_count;
    partial_bits_next = partial_bits;
    pad_seen_next     = pad_seen;
    n_data            = 2'd0;
    data[0]           = word[23:16];
    data[1]           = word[15:8];
    data[2]           = word[7:0];
    if (!pad_seen) begin
      if (char_q == PadChar) begin
        if (sextet_count == 2'd3) begin
          n_data = 2'd2;
        end else if (sextet_count == 2'd2) begin
          n_data = 2'd1;
        end
        sextet_count_next = 2'd0;
        partial_bits_next = '0;
        pad_seen_next     = 1'b1;
      end else if (lk.hit) begin
        if (sextet_count == 2'd3) begin
          n_data            = 2'd3;
          sextet_count_next = 2'd0;
          partial_bits_next = '0;
        end else begin
          case (sextet_count)
            2'd0:    partial_bits_next[17:12] = lk.value;
            2'd1:    partial_bits_next[11:6]  = lk.value;
            default: partial_bits_next[5:0]   = lk.value;
          endcase
          sextet_count_next = sextet_count + 2'd1;
        end
      end
    end
    code = (sextet_count_next != 2'd0 && !pad_seen_next) ? StatusIncomplete : StatusOk;
    n_total = CountW'(n_data) + CountW'(eot_q);
  end

  always_comb begin
    group.count = n_total;
    for (int i = 0; i < MaxResults; i++) begin
      group.item[i] = '0;
      if (i < 3 && IdxW'(i) < n_data) begin
        group.item[i].data = data[i];
      end else if (i == int'(n_data) && eot_q) begin
        group.item[i].is_status   = 1'b1;
        group.item[i].status_code = code;
      end
      group.item[i].last = (CountW'(i + 1) == n_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_count <= '0;
      partial_bits <= '0;
      pad_seen     <= 1'b0;
    end else if (step) begin
      if (eot_q) begin
        sextet_count <= '0;
        partial_bits <= '0;
        pad_seen     <= 1'b0;
      end else begin
        sextet_count <= sextet_count_next;
        partial_bits <= partial_bits_next;
        pad_seen     <= pad_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/b64d_outbuf.sv @@
`default_nettype none

module b64d_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  b64d_pkg::group_t       group,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   is_status,
  output logic                   status_code,
  output logic                   last_of_run
);
  import b64d_pkg::*;

  result_t           items [MaxResults];
  logic [CountW-1:0] left;
  logic [IdxW-1:0]   rd;
  logic              fire;

  assign out_valid   = (left != '0);
  assign fire        = out_valid && !out_stall;
  assign free        = (left == '0) || (left == CountW'(1) && !out_stall);
  assign out_byte    = items[rd].data;
  assign is_status   = items[rd].is_status;
  assign status_code = items[rd].status_code;
  assign last_of_run = items[rd].last;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) begin
        items[i] <= group.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      rd   <= '0;
    end else if (load) begin
      left <= group.count;
      rd   <= '0;
    end else if (fire) begin
      left <= left - CountW'(1);
      rd   <= rd + IdxW'(1);
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_base64_stream_decoder.sv @@
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  typedef result_t [0:2] trio_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       typed;
    logic [1:0] n;
    trio_t      r;
  } row_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomChars = 450;

  localparam result_t Blank      = '0;
  localparam result_t EndOk      = '{data: 8'h00, is_status: 1'b1,
                                     status_code: StatusOk, last: 1'b1};
  localparam result_t EndShort   = '{data: 8'h00, is_status: 1'b1,
                                     status_code: StatusIncomplete, last: 1'b1};
  localparam result_t ByteFF     = '{data: 8'hFF, is_status: 1'b0,
                                     status_code: StatusOk, last: 1'b0};
  localparam result_t ByteFFLast = '{data: 8'hFF, is_status: 1'b0,
                                     status_code: StatusOk, last: 1'b1};
  localparam trio_t   NoBeats    = '{Blank, Blank, Blank};

  localparam row_t DirRows [28] = '{
    '{"=",   1'b0, 1'b1, 2'd0, NoBeats},
    '{"A",   1'b1, 1'b1, 2'd1, '{EndOk, Blank, Blank}},
    '{8'h00, 1'b0, 1'b1, 2'd0, NoBeats},
    '{"/",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"/",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"/",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"/",   1'b0, 1'b1, 2'd3, '{ByteFF, ByteFF, ByteFFLast}},
    '{8'hFF, 1'b0, 1'b1, 2'd0, NoBeats},
    '{"+",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"9",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"z",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"0",   1'b1, 1'b0, 2'd0, NoBeats},
    '{"A",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"B",   1'b1, 1'b1, 2'd1, '{EndShort, Blank, Blank}},
    '{"Q",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"=",   1'b1, 1'b1, 2'd1, '{EndOk, Blank, Blank}},
    '{"T",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"W",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"E",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"=",   1'b1, 1'b0, 2'd0, NoBeats},
    '{"S",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"Q",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"=",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"=",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"a",   1'b1, 1'b0, 2'd0, NoBeats},
    '{"Z",   1'b0, 1'b0, 2'd0, NoBeats},
    '{"g",   1'b0, 1'b0, 2'd0, NoBeats},
    '{8'h0A, 1'b1, 1'b0, 2'd0, NoBeats}
  };

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_char     = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] out_byte;
  logic       is_status;
  logic       status_code;
  logic       last_of_run;

  logic [1:0]  grp_cnt  = '0;
  logic [17:0] grp_bits = '0;
  logic        pad_hit  = 1'b0;

  result_t awaited[$];
  row_t    cur_row;
  bit      calm = 1'b0;
  int      errors = 0;
  int      useful_chars = 0;
  int      quiet_cycles = 0;

  base64_stream_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_status   (is_status),
    .status_code (status_code),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int alphabet_index(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return int'(ch) - 65;
    if (ch >= "a" && ch <= "z") return int'(ch) - 97 + 26;
    if (ch >= "0" && ch <= "9") return int'(ch) - 48 + 52;
    if (ch == PlusChar) return 62;
    if (ch == SlashChar) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(input int idx);
    if (idx < 26) return 8'(65 + idx);
    if (idx < 52) return 8'(97 + idx - 26);
    if (idx < 62) return 8'(48 + idx - 52);
    return (idx == 62) ? PlusChar : SlashChar;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (alphabet_index(ch) >= 0 || ch == PadChar);
    return ch;
  endfunction

  function automatic row_t plain(input logic [7:0] ch, input logic eot);
    return '{ch: ch, eot: eot, typed: 1'b0, n: 2'd0, r: NoBeats};
  endfunction

  // Advance the decoder state by one character; queue its results when keep is set.
  function automatic void decode_char(input logic [7:0] ch, input logic eot, input bit keep);
    result_t     beats [4];
    int          nb;
    int          v;
    logic [23:0] word;
    nb = 0;
    if (!pad_hit) begin
      if (ch == PadChar) begin
        word = {grp_bits, 6'd0};
        if (grp_cnt >= 2'd2) begin
          beats[nb] = '{word[23:16], 1'b0, StatusOk, 1'b0};
          nb = nb + 1;
        end
        if (grp_cnt == 2'd3) begin
          beats[nb] = '{word[15:8], 1'b0, StatusOk, 1'b0};
          nb = nb + 1;
        end
        grp_cnt  = '0;
        grp_bits = '0;
        pad_hit  = 1'b1;
      end else begin
        v = alphabet_index(ch);
        if (v >= 0) begin
          if (grp_cnt == 2'd3) begin
            word = {grp_bits, v[5:0]};
            beats[0] = '{word[23:16], 1'b0, StatusOk, 1'b0};
            beats[1] = '{word[15:8], 1'b0, StatusOk, 1'b0};
            beats[2] = '{word[7:0], 1'b0, StatusOk, 1'b0};
            nb = 3;
            grp_cnt  = '0;
            grp_bits = '0;
          end else begin
            grp_bits[17 - 6 * grp_cnt -: 6] = v[5:0];
            grp_cnt = grp_cnt + 2'd1;
          end
        end
      end
    end
    if (eot) begin
      beats[nb] = '{8'h00, 1'b1,
                    (grp_cnt != 2'd0 && !pad_hit) ? StatusIncomplete : StatusOk, 1'b0};
      nb = nb + 1;
      grp_cnt  = '0;
      grp_bits = '0;
      pad_hit  = 1'b0;
    end
    if (nb > 0) beats[nb - 1].last = 1'b1;
    if (keep) for (int k = 0; k < nb; k++) awaited.push_back(beats[k]);
  endfunction

  task automatic flag(input string what, input logic [7:0] want, input logic [7:0] got);
    errors++;
    $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_byte, is_status, status_code, last_of_run};
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got %h %b %b %b",
                   $time, got.data, got.is_status, got.status_code, got.last);
        end else begin
          want = awaited.pop_front();
          if (got.data !== want.data) flag("out_byte", want.data, got.data);
          if (got.is_status !== want.is_status)
            flag("is_status", want.is_status, got.is_status);
          if (got.status_code !== want.status_code)
            flag("status_code", want.status_code, got.status_code);
          if (got.last !== want.last) flag("last_of_run", want.last, got.last);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        decode_char(in_char, end_of_text, !cur_row.typed);
        if (cur_row.typed)
          for (int k = 0; k < int'(cur_row.n); k++) awaited.push_back(cur_row.r[k]);
      end
    end
  end

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 25);

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t no beat for %0d cycles", $time, StallLimit);
      $display("tb_base64_stream_decoder: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic put_char(input row_t row);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= row.ch;
    end_of_text <= row.eot;
    cur_row = row;
    if (alphabet_index(row.ch) >= 0 || row.ch == PadChar || row.eot) useful_chars++;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic put_text();
    logic [7:0] txt[$];
    int groups;
    int tail;
    int style;
    groups = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
    tail   = $urandom_range(0, 3);
    style  = $urandom_range(0, 9);
    if (style == 0) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
    end else begin
      for (int k = 0; k < 4 * groups + tail; k++) begin
        if ($urandom_range(11) == 0) txt.push_back(noise_char());
        txt.push_back(alphabet_char($urandom_range(63)));
      end
      if (style <= 6) begin
        if (tail == 2) txt.push_back(PadChar);
        if (tail != 0) txt.push_back(PadChar);
      end else if (style == 7) begin
        txt.push_back(PadChar);
        repeat ($urandom_range(1, 4))
          txt.push_back($urandom_range(3) == 0 ? PadChar : alphabet_char($urandom_range(63)));
      end
    end
    if (txt.size() == 0) txt.push_back(noise_char());
    foreach (txt[k]) put_char(plain(txt[k], k == txt.size() - 1));
  endtask

  initial begin
    int texts;
    cur_row = plain(8'h00, 1'b0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (DirRows[i]) put_char(DirRows[i]);
    texts = 0;
    useful_chars = 0;
    while (useful_chars < RandomChars) begin
      calm = (texts >= 25 && texts < 40);
      if (texts == 12 || texts == 50) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited.size() != 0);
      end
      put_text();
      texts++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
    repeat (12) @(negedge clk);
    if (errors == 0)
      $display("tb_base64_stream_decoder: done, clean");
    else
      $display("tb_base64_stream_decoder: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/b64d_pkg.sv
rtl/core/b64d_decode.sv
rtl/core/b64d_outbuf.sv
rtl/core/base64_stream_decoder.sv
dv/tb_base64_stream_decoder.sv
